// ===== hw/rtl/quaternion_multiply_rotate_macros.svh =====
// Assertion macros shared by the quaternion multiply/rotate RTL.
// Each macro expects clk and arst_n in scope; define ASSERT_OFF to drop them.
`ifndef QUATERNION_MULTIPLY_ROTATE_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define QMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition never holds outside reset.
`define QMR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define QMR_ASSERT(lbl, prop, msg)

`define QMR_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/qmr_pkg.sv =====
// Types, widths and helpers for the quaternion multiply/rotate block.
// No dependencies; used by every module of the block.
`default_nettype none

package qmr_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_W = 13;

	// first Hamilton product: a * b
	localparam int PROD1_W = 2 * DATA_W;
	localparam int SUM1_W  = PROD1_W + 2;
	localparam int ACC1_W  = SUM1_W + 1;
	localparam int T_W     = ACC1_W - FRAC_W;

	// second Hamilton product: t * conj(a)
	localparam int PROD2_W = T_W + DATA_W;
	localparam int SUM2_W  = PROD2_W + 2;
	localparam int ACC2_W  = SUM2_W + 1;
	localparam int R2_W    = ACC2_W - FRAC_W;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	localparam logic CMD_PRODUCT = 1'b0;
	localparam logic CMD_ROTATE  = 1'b1;

	typedef logic signed [DATA_W-1:0] comp_t;

	localparam comp_t COMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam comp_t COMP_MIN = ~COMP_MAX;

	localparam logic signed [ACC1_W-1:0] RND1 = ACC1_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [ACC2_W-1:0] RND2 = ACC2_W'(64'sd1 <<< (FRAC_W - 1));

	localparam logic signed [R2_W-1:0] SAT_MAX = R2_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam logic signed [R2_W-1:0] SAT_MIN = ~SAT_MAX;

	typedef struct packed {
		logic         cmd;
		comp_t [3:0]  a;
		comp_t [3:0]  b;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic  clip;
		comp_t val;
	} sat_t;

	function automatic sat_t qmr_sat(input logic signed [R2_W-1:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[DATA_W-1:0];
		if (v > SAT_MAX) begin
			r.clip = 1'b1;
			r.val  = COMP_MAX;
		end else if (v < SAT_MIN) begin
			r.clip = 1'b1;
			r.val  = COMP_MIN;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qmr_front.sv =====
// Input stage: takes one item per transfer, zeroes b_w on rotate commands
// and hands the item to the queue. Depends on qmr_pkg.
`default_nettype none

module qmr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  qmr_pkg::comp_t        a_w,
	input  qmr_pkg::comp_t        a_x,
	input  qmr_pkg::comp_t        a_y,
	input  qmr_pkg::comp_t        a_z,
	input  qmr_pkg::comp_t        b_w,
	input  qmr_pkg::comp_t        b_x,
	input  qmr_pkg::comp_t        b_y,
	input  qmr_pkg::comp_t        b_z,
	input  qmr_pkg::fifo_stat_t   fifo_stat,
	output logic                  push,
	output qmr_pkg::item_t        push_item
);
	import qmr_pkg::*;

	logic  valid_q;
	item_t item_q;
	item_t item_in;
	logic  accept;

	always_comb begin
		item_in.cmd  = command;
		item_in.a[0] = a_w;
		item_in.a[1] = a_x;
		item_in.a[2] = a_y;
		item_in.a[3] = a_z;
		// a rotated vector is a pure quaternion
		item_in.b[0] = (command == CMD_ROTATE) ? COMP_MIN ^ COMP_MIN : b_w;
		item_in.b[1] = b_x;
		item_in.b[2] = b_y;
		item_in.b[3] = b_z;
	end

	assign push      = valid_q && !fifo_stat.full;
	assign in_stall  = valid_q && fifo_stat.full;
	assign accept    = in_valid && !in_stall;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_in;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/qmr_fifo.sv =====
// Short queue between the input stage and the arithmetic pipeline.
// Depends on qmr_pkg and the assertion macro header.
`default_nettype none
`include "quaternion_multiply_rotate_macros.svh"

module qmr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qmr_pkg::item_t       push_item,
	input  logic                 pop,
	output qmr_pkg::item_t       pop_item,
	output qmr_pkg::fifo_stat_t  stat
);
	import qmr_pkg::*;

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign stat.full  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`QMR_ASSERT_NEVER(a_fifo_no_overflow, push && stat.full, "push into full queue")
	`QMR_ASSERT_NEVER(a_fifo_no_underflow, pop && stat.empty, "pop from empty queue")
	`QMR_ASSERT(a_fifo_fill, push && !pop |=> !stat.empty, "queue empty after lone push")

endmodule

`default_nettype wire

// ===== hw/rtl/qmr_back.sv =====
// Arithmetic pipeline: two Hamilton products with rounding, then saturation
// into the output register. Depends on qmr_pkg and the assertion macro header.
`default_nettype none
`include "quaternion_multiply_rotate_macros.svh"

module qmr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qmr_pkg::fifo_stat_t  fifo_stat,
	input  qmr_pkg::item_t       pop_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output qmr_pkg::comp_t       r_w,
	output qmr_pkg::comp_t       r_x,
	output qmr_pkg::comp_t       r_y,
	output qmr_pkg::comp_t       r_z,
	output logic                 saturated
);
	import qmr_pkg::*;

	// stage 1: a * b products
	logic                        v_s1;
	logic                        cmd_s1;
	comp_t                       a_s1 [4];
	logic signed [PROD1_W-1:0]   p_s1 [4][4];

	// stage 2: rounded first product t
	logic                        v_s2;
	logic                        cmd_s2;
	comp_t                       a_s2 [4];
	logic signed [T_W-1:0]       t_s2 [4];

	// stage 3: t * a products
	logic                        v_s3;
	logic                        cmd_s3;
	logic signed [T_W-1:0]       t_s3 [4];
	logic signed [PROD2_W-1:0]   q_s3 [4][4];

	// output register
	logic                        out_v_q;
	comp_t                       r_q [4];
	logic                        sat_q;

	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [ACC1_W-1:0]    acc1 [4];
	logic signed [T_W-1:0]       t_nxt [4];
	logic signed [ACC2_W-1:0]    acc2 [4];
	logic signed [R2_W-1:0]      fin [4];
	sat_t                        sat_r [4];

	assign rdy4 = !out_v_q || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = !fifo_stat.empty && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pop;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				out_v_q <= v_s3;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= pop_item.cmd;
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= pop_item.a[i];
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= PROD1_W'(pop_item.a[i]) * PROD1_W'(pop_item.b[j]);
				end
			end
		end
	end

	// Hamilton sums of a * b, rounded half up
	always_comb begin
		acc1[0] = ACC1_W'(p_s1[0][0]) - ACC1_W'(p_s1[1][1])
			- ACC1_W'(p_s1[2][2]) - ACC1_W'(p_s1[3][3]) + RND1;
		acc1[1] = ACC1_W'(p_s1[0][1]) + ACC1_W'(p_s1[1][0])
			+ ACC1_W'(p_s1[2][3]) - ACC1_W'(p_s1[3][2]) + RND1;
		acc1[2] = ACC1_W'(p_s1[0][2]) - ACC1_W'(p_s1[1][3])
			+ ACC1_W'(p_s1[2][0]) + ACC1_W'(p_s1[3][1]) + RND1;
		acc1[3] = ACC1_W'(p_s1[0][3]) + ACC1_W'(p_s1[1][2])
			- ACC1_W'(p_s1[2][1]) + ACC1_W'(p_s1[3][0]) + RND1;
		for (int i = 0; i < 4; i++) begin
			t_nxt[i] = T_W'(acc1[i] >>> FRAC_W);
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cmd_s2 <= cmd_s1;
			for (int i = 0; i < 4; i++) begin
				a_s2[i] <= a_s1[i];
				t_s2[i] <= t_nxt[i];
			end
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			cmd_s3 <= cmd_s2;
			for (int i = 0; i < 4; i++) begin
				t_s3[i] <= t_s2[i];
				for (int j = 0; j < 4; j++) begin
					q_s3[i][j] <= PROD2_W'(t_s2[i]) * PROD2_W'(a_s2[j]);
				end
			end
		end
	end

	// Hamilton sums of t * conj(a); a product command takes t as is
	always_comb begin
		acc2[0] = ACC2_W'(q_s3[0][0]) + ACC2_W'(q_s3[1][1])
			+ ACC2_W'(q_s3[2][2]) + ACC2_W'(q_s3[3][3]) + RND2;
		acc2[1] = ACC2_W'(q_s3[1][0]) - ACC2_W'(q_s3[0][1])
			- ACC2_W'(q_s3[2][3]) + ACC2_W'(q_s3[3][2]) + RND2;
		acc2[2] = ACC2_W'(q_s3[1][3]) - ACC2_W'(q_s3[0][2])
			+ ACC2_W'(q_s3[2][0]) - ACC2_W'(q_s3[3][1]) + RND2;
		acc2[3] = ACC2_W'(q_s3[2][1]) - ACC2_W'(q_s3[0][3])
			- ACC2_W'(q_s3[1][2]) + ACC2_W'(q_s3[3][0]) + RND2;
		for (int i = 0; i < 4; i++) begin
			if (cmd_s3 == CMD_ROTATE) begin
				fin[i] = R2_W'(acc2[i] >>> FRAC_W);
			end else begin
				fin[i] = R2_W'(t_s3[i]);
			end
			sat_r[i] = qmr_sat(fin[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int i = 0; i < 4; i++) begin
				r_q[i] <= sat_r[i].val;
			end
			sat_q <= sat_r[0].clip || sat_r[1].clip || sat_r[2].clip || sat_r[3].clip;
		end
	end

	assign out_valid = out_v_q;
	assign r_w       = r_q[0];
	assign r_x       = r_q[1];
	assign r_y       = r_q[2];
	assign r_z       = r_q[3];
	assign saturated = sat_q;

	`QMR_ASSERT(a_s3_hold, v_s3 && !rdy4 |=> v_s3 && $stable(cmd_s3), "stage 3 lost a held item")
	`QMR_ASSERT(a_s1_advance, v_s1 && rdy2 |=> v_s2, "stage 1 item dropped")
	`QMR_ASSERT(a_sat_limit, out_v_q && sat_q |-> r_q[0] == COMP_MAX || r_q[0] == COMP_MIN || r_q[1] == COMP_MAX || r_q[1] == COMP_MIN || r_q[2] == COMP_MAX || r_q[2] == COMP_MIN || r_q[3] == COMP_MAX || r_q[3] == COMP_MIN, "saturated flag without clipped component")

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_multiply_rotate.sv =====
// Quaternion Hamilton product / vector rotation, signed Q2.13 components.
// Input to result valid: input register, queue write, multiply stage, rounding
// stage, second multiply stage, saturating output register. Each product stage
// has 16 parallel multipliers; one item per cycle unless out_stall backs up.
// Reset (arst_n low, asynchronous) empties the input register, queue and pipeline.
`default_nettype none

module quaternion_multiply_rotate (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  qmr_pkg::comp_t        a_w,
	input  qmr_pkg::comp_t        a_x,
	input  qmr_pkg::comp_t        a_y,
	input  qmr_pkg::comp_t        a_z,
	input  qmr_pkg::comp_t        b_w,
	input  qmr_pkg::comp_t        b_x,
	input  qmr_pkg::comp_t        b_y,
	input  qmr_pkg::comp_t        b_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output qmr_pkg::comp_t        r_w,
	output qmr_pkg::comp_t        r_x,
	output qmr_pkg::comp_t        r_y,
	output qmr_pkg::comp_t        r_z,
	output logic                  saturated
);
	import qmr_pkg::*;

	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	item_t      push_item;
	item_t      pop_item;

	qmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.a_w       (a_w),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_w       (b_w),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_item (push_item)
	);

	qmr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (fifo_stat)
	);

	qmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.r_w       (r_w),
		.r_x       (r_x),
		.r_y       (r_y),
		.r_z       (r_z),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

// ===== sim/qmr_checker.sv =====
// Result checker for quaternion_multiply_rotate: predicts every transfer on the
// input channel and compares it with the result channel in order.
// Depends on qmr_pkg for component types, limits and command codes.
`timescale 1ns / 100ps

module qmr_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           command,
	input  qmr_pkg::comp_t a_w,
	input  qmr_pkg::comp_t a_x,
	input  qmr_pkg::comp_t a_y,
	input  qmr_pkg::comp_t a_z,
	input  qmr_pkg::comp_t b_w,
	input  qmr_pkg::comp_t b_x,
	input  qmr_pkg::comp_t b_y,
	input  qmr_pkg::comp_t b_z,
	input  logic           out_valid,
	input  logic           out_stall,
	input  qmr_pkg::comp_t r_w,
	input  qmr_pkg::comp_t r_x,
	input  qmr_pkg::comp_t r_y,
	input  qmr_pkg::comp_t r_z,
	input  logic           saturated,
	output int             mismatches,
	output int             n_pending
);
	import qmr_pkg::*;

	typedef struct packed {
		comp_t w;
		comp_t x;
		comp_t y;
		comp_t z;
		logic  sat;
	} quat_res_t;

	quat_res_t expected_results[$];

	// exact sums of the Hamilton product p*q
	function automatic void hamilton_sums(
		input  longint pw, px, py, pz, qw, qx, qy, qz,
		output longint sw, sx, sy, sz
	);
		sw = pw*qw - px*qx - py*qy - pz*qz;
		sx = pw*qx + px*qw + py*qz - pz*qy;
		sy = pw*qy - px*qz + py*qw + pz*qx;
		sz = pw*qz + px*qy - py*qx + pz*qw;
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic longint round_frac(input longint v);
		return (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
	endfunction

	function automatic sat_t clamp_comp(input longint v);
		sat_t r;
		longint hi, lo;
		hi = longint'(COMP_MAX);
		lo = longint'(COMP_MIN);
		r.clip = 1'b0;
		r.val  = comp_t'(v);
		if (v > hi) begin
			r.clip = 1'b1;
			r.val  = COMP_MAX;
		end else if (v < lo) begin
			r.clip = 1'b1;
			r.val  = COMP_MIN;
		end
		return r;
	endfunction

	function automatic quat_res_t multiply_or_rotate(
		input logic cmd,
		input comp_t aw, ax, ay, az, bw, bx, by, bz
	);
		longint law, lax, lay, laz, lbw, lbx, lby, lbz;
		longint sw, sx, sy, sz, tw, tx, ty, tz;
		sat_t cw, cx, cy, cz;
		quat_res_t r;
		law = longint'(aw); lax = longint'(ax); lay = longint'(ay); laz = longint'(az);
		lbw = longint'(bw); lbx = longint'(bx); lby = longint'(by); lbz = longint'(bz);
		if (cmd == CMD_ROTATE) begin
			// a*v is rounded but not clamped, then times conj(a)
			hamilton_sums(law, lax, lay, laz, 0, lbx, lby, lbz, sw, sx, sy, sz);
			tw = round_frac(sw);
			tx = round_frac(sx);
			ty = round_frac(sy);
			tz = round_frac(sz);
			hamilton_sums(tw, tx, ty, tz, law, -lax, -lay, -laz, sw, sx, sy, sz);
		end else begin
			hamilton_sums(law, lax, lay, laz, lbw, lbx, lby, lbz, sw, sx, sy, sz);
		end
		cw = clamp_comp(round_frac(sw));
		cx = clamp_comp(round_frac(sx));
		cy = clamp_comp(round_frac(sy));
		cz = clamp_comp(round_frac(sz));
		r.w   = cw.val;
		r.x   = cx.val;
		r.y   = cy.val;
		r.z   = cz.val;
		r.sat = cw.clip | cx.clip | cy.clip | cz.clip;
		return r;
	endfunction

	always @(posedge clk) begin
		quat_res_t exp_r;
		if (!arst_n) begin
			mismatches = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(multiply_or_rotate(command, a_w, a_x, a_y, a_z,
					b_w, b_x, b_y, b_z));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d sat=%b",
							$realtime, r_w, r_x, r_y, r_z, saturated);
				end else begin
					exp_r = expected_results.pop_front();
					if (r_w !== exp_r.w || r_x !== exp_r.x || r_y !== exp_r.y ||
						r_z !== exp_r.z || saturated !== exp_r.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d sat=%b, ",
								$realtime, exp_r.w, exp_r.x, exp_r.y, exp_r.z, exp_r.sat,
								"got w=%0d x=%0d y=%0d z=%0d sat=%b",
								r_w, r_x, r_y, r_z, saturated);
					end
				end
			end
		end
		n_pending = expected_results.size();
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for quaternion_multiply_rotate: clock, reset, bursty stimulus
// and receiver stalls; the verdict comes from qmr_checker.
// Depends on qmr_pkg, quaternion_multiply_rotate and qmr_checker.
`timescale 1ns / 100ps

module tb_top;
	import qmr_pkg::*;

	localparam int N_RANDOM   = 1400;
	localparam int HOLD_LEN   = 300;
	localparam int IDLE_LIMIT = 2000;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	logic  command;
	comp_t a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
	logic  out_valid;
	logic  out_stall;
	comp_t r_w, r_x, r_y, r_z;
	logic  saturated;
	int    hold_req;
	int    mismatches;
	int    n_pending;
	int    idle_cycles;

	quaternion_multiply_rotate i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.a_w       (a_w),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_w       (b_w),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.r_w       (r_w),
		.r_x       (r_x),
		.r_y       (r_y),
		.r_z       (r_z),
		.saturated (saturated)
	);

	qmr_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.a_w        (a_w),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_w        (b_w),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.r_w        (r_w),
		.r_x        (r_x),
		.r_y        (r_y),
		.r_z        (r_z),
		.saturated  (saturated),
		.mismatches (mismatches),
		.n_pending  (n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one item from a falling edge and hold it until the transfer.
	task automatic drive_item(input logic cmd,
		input int aw, input int ax, input int ay, input int az,
		input int bw, input int bx, input int by, input int bz);
		in_valid = 1'b1;
		command  = cmd;
		a_w = comp_t'(aw); a_x = comp_t'(ax); a_y = comp_t'(ay); a_z = comp_t'(az);
		b_w = comp_t'(bw); b_x = comp_t'(bx); b_y = comp_t'(by); b_z = comp_t'(bz);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic comp_t pick_comp(input int style);
		int v;
		case (style)
			0: v = $urandom;
			1: v = int'($urandom_range(0, 11584)) - 5792;
			default: begin
				case ($urandom_range(0, 6))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					3: v = 8192;
					4: v = -8192;
					5: v = -1;
					default: v = 1;
				endcase
			end
		endcase
		return comp_t'(v);
	endfunction

	task automatic drive_random_item();
		int    mix;
		int    st [8];
		comp_t c [8];
		mix = $urandom_range(0, 99);
		for (int i = 0; i < 8; i++) begin
			// mostly unit-sized quaternions, the rest full range or edge values
			if (mix < 55)
				st[i] = 1;
			else if (mix < 80)
				st[i] = 0;
			else
				st[i] = $urandom_range(0, 2);
			c[i] = pick_comp(st[i]);
		end
		drive_item($urandom_range(0, 1) ? CMD_ROTATE : CMD_PRODUCT,
			int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]),
			int'(c[4]), int'(c[5]), int'(c[6]), int'(c[7]));
	endtask

	// Receiver stalls: a random stall rate, redrawn when the left counter runs out, or a long hold-off on request.
	initial begin
		int stall_pct;
		int left;
		int holds_done;
		out_stall  = 1'b0;
		stall_pct  = 0;
		left       = 0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				out_stall = 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				if (left == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 15;
						3: stall_pct = 50;
						default: stall_pct = 85;
					endcase
					left = 64;
				end
				left--;
				out_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL quaternion_multiply_rotate");
			$finish;
		end
	end

	initial begin
		int n_sent;
		int burst;
		int gap;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = CMD_PRODUCT;
		a_w = '0; a_x = '0; a_y = '0; a_z = '0;
		b_w = '0; b_x = '0; b_y = '0; b_z = '0;
		hold_req = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// products: zero, identity, extremes, w-only clip, rounding ties
		drive_item(CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
		drive_item(CMD_PRODUCT, 8192, 0, 0, 0, 1000, -2000, 3000, -4000);
		drive_item(CMD_PRODUCT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		drive_item(CMD_PRODUCT, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768);
		drive_item(CMD_PRODUCT, -32768, 0, 0, 0, -32768, 0, 0, 0);
		drive_item(CMD_PRODUCT, 1, 0, 0, 0, 4096, 0, 0, 0);
		drive_item(CMD_PRODUCT, -1, 0, 0, 0, 4096, 0, 0, 0);
		drive_item(CMD_PRODUCT, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
		drive_item(CMD_PRODUCT, -1, -1, -1, -1, -1, -1, -1, -1);
		drive_item(CMD_PRODUCT, 5793, 5793, 0, 0, 0, 1, 4096, -4096);
		// rotations: identity with b_w ignored, quarter turn, extremes, wide intermediate
		drive_item(CMD_ROTATE, 8192, 0, 0, 0, 32767, 1234, -5678, 4321);
		drive_item(CMD_ROTATE, 8192, 0, 0, 0, -32768, 1234, -5678, 4321);
		drive_item(CMD_ROTATE, 5793, 0, 0, 5793, 0, 8192, 0, 0);
		drive_item(CMD_ROTATE, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		drive_item(CMD_ROTATE, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768);
		drive_item(CMD_ROTATE, 32767, 32767, 32767, 32767, -32768, -32768, 32767, -32768);
		drive_item(CMD_ROTATE, 0, 0, 0, 0, 12345, -32768, 32767, 77);
		drive_item(CMD_ROTATE, 0, 32767, 0, 0, 0, 0, 32767, 0);
		drive_item(CMD_ROTATE, -1, -1, -1, -1, 0, -1, -1, -1);
		drive_item(CMD_ROTATE, 1, 0, 0, 0, 0, 4096, -4096, 8191);

		n_sent = 0;
		while (n_sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n_sent < N_RANDOM; i++) begin
				if (n_sent == 400 || n_sent == 1200)
					hold_req++;
				if (n_sent == 900) begin
					// drain the block completely before going on
					in_valid = 1'b0;
					wait (n_pending == 0);
					@(negedge clk);
				end
				drive_random_item();
				n_sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid = 1'b0;

		wait (n_pending == 0);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASS quaternion_multiply_rotate");
		else
			$display("FAIL quaternion_multiply_rotate");
		$finish;
	end

endmodule
